### src/bary_pkg.sv
// ----------------------------------------------------------------------------
// bary_pkg
// Shared widths, payload types and control structs for the barycentric UV
// interpolator.
// ----------------------------------------------------------------------------
package bary_pkg;

  localparam int WFB = 16;  // weight fraction bits

  typedef struct packed {
    logic [47:0] vert0;
    logic [47:0] vert1;
    logic [47:0] vert2;
    logic [47:0] sample_point;
    logic [31:0] tex0;
    logic [31:0] tex1;
    logic [31:0] tex2;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
    logic               degenerate;
  } out_item_t;

  // classified work handed from front to back
  typedef struct packed {
    logic signed [35:0] d00;
    logic signed [35:0] d01;
    logic signed [35:0] d11;
    logic signed [35:0] d20;
    logic signed [35:0] d21;
    logic [31:0]        tex0;
    logic [31:0]        tex1;
    logic [31:0]        tex2;
  } work_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_ctl_t;

  localparam int NUM_W = 72;          // |numerator| bits
  localparam int DIV_W = NUM_W + WFB; // dividend bits
  localparam int DEN_W = 72;

  // side data that rides through a divider next to its quotient
  typedef struct packed {
    logic        flag;
    logic        neg;
    logic [47:0] tex;
  } div_tag_t;

endpackage

### src/bary_if.sv
// ----------------------------------------------------------------------------
// bary_in_if / bary_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface bary_in_if;
  logic              valid;
  logic              ready;
  bary_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bary_out_if;
  logic               valid;
  logic               ready;
  bary_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/barycentric_uv_interpolate.sv
// ----------------------------------------------------------------------------
// barycentric_uv_interpolate
// Barycentric weights of a point in a triangle and the weighted UV pair.
// ----------------------------------------------------------------------------
// One item per clock sustained while the output is taken; most of the pipeline
// is the 88-stage bit-per-stage divider pipelines that form the two weights.
// A two-stage front end computes dot products into
// a four-entry queue; the back end stalls as a whole when the output is not
// taken.
module barycentric_uv_interpolate (
  input logic clk,
  input logic rst,
  bary_in_if.sink    in_ch,
  bary_out_if.source out_ch
);
  logic q_room, f_valid, q_valid, q_ready;
  bary_pkg::work_t f_data, q_data;
  bary_pkg::q_ctl_t qc;

  bary_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_data(in_ch.data), .q_room(q_room), .out_valid(f_valid), .out_data(f_data));

  assign qc.push = f_valid && q_room;
  assign qc.full = !q_room;

  bary_queue u_queue (
    .clk(clk), .rst(rst), .ctl_in(qc), .room(q_room), .wr_data(f_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data));

  bary_back u_back (
    .clk(clk), .rst(rst), .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.data.degenerate |->
      out_ch.data.tex_u == 16'sd0 && out_ch.data.tex_v == 16'sd0)
    else $error("degenerate result with nonzero uv");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    qc.push |-> !qc.full) else $error("queue push while full");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result dropped under stall");
endmodule

### src/bary_front.sv
// ----------------------------------------------------------------------------
// bary_front
// Two-stage front end: edge vectors and products, then the five dot products.
// Stalls as a unit when the queue cannot take a new entry.
// ----------------------------------------------------------------------------
module bary_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bary_pkg::in_item_t  in_data,
  input  logic                q_room,
  output logic                out_valid,
  output bary_pkg::work_t     out_data
);
  logic signed [16:0] e0 [3];
  logic signed [16:0] e1 [3];
  logic signed [16:0] pp [3];
  logic signed [33:0] p00 [3], p01 [3], p11 [3], p20 [3], p21 [3];
  logic [95:0] t1;
  logic s1_valid, advance;

  assign advance  = !out_valid || q_room;
  assign in_ready = advance;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e0[k] = $signed({1'b0, in_data.vert1[16*k +: 16]}) -
              $signed({1'b0, in_data.vert0[16*k +: 16]});
      e1[k] = $signed({1'b0, in_data.vert2[16*k +: 16]}) -
              $signed({1'b0, in_data.vert0[16*k +: 16]});
      pp[k] = $signed({1'b0, in_data.sample_point[16*k +: 16]}) -
              $signed({1'b0, in_data.vert0[16*k +: 16]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= in_valid;
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < 3; k++) begin
        p00[k] <= 34'(e0[k] * e0[k]);
        p01[k] <= 34'(e0[k] * e1[k]);
        p11[k] <= 34'(e1[k] * e1[k]);
        p20[k] <= 34'(pp[k] * e0[k]);
        p21[k] <= 34'(pp[k] * e1[k]);
      end
      t1 <= {in_data.tex0, in_data.tex1, in_data.tex2};
      out_data.d00 <= 36'(p00[0]) + 36'(p00[1]) + 36'(p00[2]);
      out_data.d01 <= 36'(p01[0]) + 36'(p01[1]) + 36'(p01[2]);
      out_data.d11 <= 36'(p11[0]) + 36'(p11[1]) + 36'(p11[2]);
      out_data.d20 <= 36'(p20[0]) + 36'(p20[1]) + 36'(p20[2]);
      out_data.d21 <= 36'(p21[0]) + 36'(p21[1]) + 36'(p21[2]);
      out_data.tex0 <= t1[95:64];
      out_data.tex1 <= t1[63:32];
      out_data.tex2 <= t1[31:0];
    end
  end
endmodule

### src/bary_queue.sv
// ----------------------------------------------------------------------------
// bary_queue
// Four-entry queue of classified work between front and back.
// ----------------------------------------------------------------------------
module bary_queue (
  input  logic            clk,
  input  logic            rst,
  input  bary_pkg::q_ctl_t ctl_in,
  output logic            room,
  input  bary_pkg::work_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output bary_pkg::work_t rd_data
);
  bary_pkg::work_t mem [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  logic pop;

  assign pop      = rd_valid && rd_ready;
  assign rd_valid = cnt != 3'd0;
  assign rd_data  = mem[rp];
  // room counts a pop in the same cycle
  assign room     = (cnt != 3'd4) || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (ctl_in.push) wp <= wp + 2'd1;
      if (pop) rp <= rp + 2'd1;
      cnt <= cnt + {2'b0, ctl_in.push} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.push) mem[wp] <= wr_data;
  end
endmodule

### src/bary_div.sv
// ----------------------------------------------------------------------------
// bary_div
// Pipelined restoring divider, one quotient bit per stage, full rate while en is high.
// Carries a tag alongside each division.
// ----------------------------------------------------------------------------
module bary_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic [bary_pkg::DIV_W-1:0] num,
  input  logic [bary_pkg::DEN_W-1:0] den,
  input  bary_pkg::div_tag_t         tag_in,
  output logic [bary_pkg::DIV_W-1:0] quo,
  output bary_pkg::div_tag_t         tag_out
);
  localparam int NW = bary_pkg::DIV_W;
  localparam int DW = bary_pkg::DEN_W;

  logic [NW-1:0]      q [1:NW];
  logic [DW:0]        r [1:NW];
  logic [DW-1:0]      d [1:NW];
  bary_pkg::div_tag_t t [1:NW];

  for (genvar i = 0; i < NW; i++) begin : g_st
    logic [NW-1:0]      q_in;
    logic [DW:0]        r_in;
    logic [DW-1:0]      d_in;
    bary_pkg::div_tag_t t_in;
    logic [DW+1:0]      sh;
    logic [DW+1:0]      trial;

    if (i == 0) begin : g_first
      assign q_in = num;
      assign r_in = '0;
      assign d_in = den;
      assign t_in = tag_in;
    end else begin : g_next
      assign q_in = q[i];
      assign r_in = r[i];
      assign d_in = d[i];
      assign t_in = t[i];
    end

    assign sh    = {r_in, q_in[NW-1]};
    assign trial = sh - {2'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        d[i+1] <= d_in;
        if (!trial[DW+1]) begin
          r[i+1] <= trial[DW:0];
          q[i+1] <= {q_in[NW-2:0], 1'b1};
        end else begin
          r[i+1] <= sh[DW:0];
          q[i+1] <= {q_in[NW-2:0], 1'b0};
        end
      end
    end

    // tag flags mark live items, so they start cleared
    always_ff @(posedge clk) begin
      if (rst) begin
        t[i+1] <= '0;
      end else if (en) begin
        t[i+1] <= t_in;
      end
    end
  end

  assign quo     = q[NW];
  assign tag_out = t[NW];
endmodule

### src/bary_back.sv
// ----------------------------------------------------------------------------
// bary_back
// Back end: denominator and numerators, two dividers, weight sums and the
// final saturation. Pipeline with a single enable tied to output space.
// ----------------------------------------------------------------------------
module bary_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bary_pkg::work_t     in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bary_pkg::out_item_t out_data
);
  localparam int NW = bary_pkg::DIV_W;
  localparam int DW = bary_pkg::DEN_W;
  localparam int WFB = bary_pkg::WFB;
  localparam int HALF = 45;  // split point of a weight for the texture products

  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // stage A: products
  logic signed [71:0] a_m0, a_m1, a_m2, a_m3, a_m4, a_m5;
  logic [95:0] a_tex;
  logic a_v;
  // stage B: differences
  logic signed [72:0] b_den, b_nv, b_nw;
  logic [95:0] b_tex;
  logic b_v;
  // stage C: magnitudes into dividers
  logic [NW-1:0] c_nv, c_nw;
  logic [DW-1:0] c_den;
  logic c_sv, c_sw, c_deg, c_v;
  logic [95:0] c_tex;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0; b_v <= 1'b0; c_v <= 1'b0;
    end else if (en) begin
      a_v <= in_valid; b_v <= a_v; c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_m0 <= 72'(in_data.d00 * in_data.d11);
      a_m1 <= 72'(in_data.d01 * in_data.d01);
      a_m2 <= 72'(in_data.d11 * in_data.d20);
      a_m3 <= 72'(in_data.d01 * in_data.d21);
      a_m4 <= 72'(in_data.d00 * in_data.d21);
      a_m5 <= 72'(in_data.d01 * in_data.d20);
      a_tex <= {in_data.tex0, in_data.tex1, in_data.tex2};
      b_den <= 73'(a_m0) - 73'(a_m1);
      b_nv  <= 73'(a_m2) - 73'(a_m3);
      b_nw  <= 73'(a_m4) - 73'(a_m5);
      b_tex <= a_tex;
      c_deg <= b_den[72] || (b_den == '0);
      c_den <= b_den[71:0];
      c_sv  <= b_nv[72];
      c_sw  <= b_nw[72];
      c_nv  <= {(b_nv[72] ? 72'(-b_nv) : b_nv[71:0]), {WFB{1'b0}}};
      c_nw  <= {(b_nw[72] ? 72'(-b_nw) : b_nw[71:0]), {WFB{1'b0}}};
      c_tex <= b_tex;
    end
  end

  // degenerate items divide by one to keep the dividers defined
  logic [DW-1:0] c_den_s;
  assign c_den_s = c_deg ? DW'(1) : c_den;

  // valid and upper texture half ride with v, degenerate and lower half with w
  logic [NW-1:0] qv, qw;
  bary_pkg::div_tag_t tag_v, tag_w;
  bary_div u_div_v (
    .clk(clk), .rst(rst), .en(en), .num(c_nv), .den(c_den_s),
    .tag_in({c_v, c_sv, c_tex[95:48]}), .quo(qv), .tag_out(tag_v));
  bary_div u_div_w (
    .clk(clk), .rst(rst), .en(en), .num(c_nw), .den(c_den_s),
    .tag_in({c_deg, c_sw, c_tex[47:0]}), .quo(qw), .tag_out(tag_w));

  // stage D: signed weights (magnitudes fit well below 90 bits)
  logic signed [89:0] d_wv, d_ww, d_wu;
  logic [95:0] d_tex;
  logic d_deg, d_v;
  logic signed [89:0] wv_s, ww_s;
  assign wv_s = tag_v.neg ? -$signed({2'b0, qv}) : $signed({2'b0, qv});
  assign ww_s = tag_w.neg ? -$signed({2'b0, qw}) : $signed({2'b0, qw});

  // lane k pairs the texture of vertex k with its weight
  logic signed [15:0] lane_u [3];
  logic signed [15:0] lane_v [3];
  logic signed [89:0] lane_w [3];
  always_comb begin
    lane_u[0] = d_tex[79:64];
    lane_u[1] = d_tex[47:32];
    lane_u[2] = d_tex[15:0];
    lane_v[0] = d_tex[95:80];
    lane_v[1] = d_tex[63:48];
    lane_v[2] = d_tex[31:16];
    lane_w[0] = d_wu;
    lane_w[1] = d_wv;
    lane_w[2] = d_ww;
  end

  // stage E: products on the signed upper and unsigned lower weight parts,
  // stage F: lane sums, stage G: recombine the two parts
  logic signed [61:0] e_uh [3], e_ul [3], e_vh [3], e_vl [3];
  logic e_deg, e_v;
  logic signed [63:0] f_uh, f_ul, f_vh, f_vl;
  logic f_deg, f_v;
  logic signed [109:0] g_su, g_sv;
  logic g_deg, g_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0; e_v <= 1'b0; f_v <= 1'b0; g_v <= 1'b0;
    end else if (en) begin
      d_v <= tag_v.flag; e_v <= d_v; f_v <= e_v; g_v <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_wv  <= wv_s;
      d_ww  <= ww_s;
      d_wu  <= (90'sd1 <<< WFB) - wv_s - ww_s;
      d_tex <= {tag_v.tex, tag_w.tex};
      d_deg <= tag_w.flag;
      for (int k = 0; k < 3; k++) begin
        e_uh[k] <= 62'(lane_u[k] * $signed(lane_w[k][89:HALF]));
        e_ul[k] <= 62'(lane_u[k] * $signed({1'b0, lane_w[k][HALF-1:0]}));
        e_vh[k] <= 62'(lane_v[k] * $signed(lane_w[k][89:HALF]));
        e_vl[k] <= 62'(lane_v[k] * $signed({1'b0, lane_w[k][HALF-1:0]}));
      end
      e_deg <= d_deg;
      f_uh  <= 64'(e_uh[0]) + 64'(e_uh[1]) + 64'(e_uh[2]);
      f_ul  <= 64'(e_ul[0]) + 64'(e_ul[1]) + 64'(e_ul[2]);
      f_vh  <= 64'(e_vh[0]) + 64'(e_vh[1]) + 64'(e_vh[2]);
      f_vl  <= 64'(e_vl[0]) + 64'(e_vl[1]) + 64'(e_vl[2]);
      f_deg <= e_deg;
      g_su  <= (110'(f_uh) <<< HALF) + 110'(f_ul);
      g_sv  <= (110'(f_vh) <<< HALF) + 110'(f_vl);
      g_deg <= f_deg;
    end
  end

  function automatic logic [15:0] finish(input logic signed [109:0] s);
    logic [109:0] a;
    logic [109:0] m;
    a = s[109] ? 110'(-s) : 110'(s);
    m = a >> WFB;
    if (s[109]) finish = (m > 110'd32768) ? 16'h8000 : 16'(-m[15:0]);
    else        finish = (m > 110'd32767) ? 16'h7fff : m[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= g_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.degenerate <= g_deg;
      out_data.tex_u <= g_deg ? 16'sd0 : finish(g_su);
      out_data.tex_v <= g_deg ? 16'sd0 : finish(g_sv);
    end
  end
endmodule

### tb/tb_barycentric_uv_interpolate.sv
// ----------------------------------------------------------------------------
// tb_barycentric_uv_interpolate
// Self-checking bench: drives triangle/point items with random gaps, predicts
// the weighted UV pair with exact 128-bit arithmetic, and compares each
// result item in order, under random output stalls.
// ----------------------------------------------------------------------------
module tb_barycentric_uv_interpolate;

  typedef logic signed [127:0] wide_t;

  logic clk;
  logic rst;

  bary_in_if  in_ch ();
  bary_out_if out_ch ();

  barycentric_uv_interpolate u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bary_pkg::in_item_t  pending_items[$];
  bary_pkg::out_item_t expected_uv[$];
  int        fail_count = 0;
  int        accepted_count = 0;
  int        send_gap = 0;
  int        take_stall = 0;
  bit        no_idle_burst = 0;

  function automatic void queue_item(bary_pkg::in_item_t it);
    pending_items = {pending_items, it};
  endfunction

  function automatic wide_t coord_at(logic [47:0] v, int k);
    wide_t c;
    c = {112'b0, v[16*k +: 16]};
    return c;
  endfunction

  function automatic wide_t tex_at(logic [31:0] t, int k);
    logic [15:0] f;
    wide_t c;
    f = t[16*k +: 16];
    c = {{112{f[15]}}, f};
    return c;
  endfunction

  // truncate toward zero, drop weight fraction, clamp to 16 bits
  function automatic logic signed [15:0] clamp_q412(wide_t s);
    wide_t m;
    m = (s < 0) ? -s : s;
    m = m >>> bary_pkg::WFB;
    if (s < 0) begin
      if (m > 32768) return 16'sh8000;
      return 16'(-m);
    end
    if (m > 32767) return 16'sh7fff;
    return 16'(m);
  endfunction

  function automatic bary_pkg::out_item_t interp_uv(bary_pkg::in_item_t it);
    wide_t e0[3], e1[3], p[3];
    wide_t d00, d01, d11, d20, d21, denom, nv, nw, wv, ww, wu, su, sv, one;
    bary_pkg::out_item_t r;
    d00 = 0; d01 = 0; d11 = 0; d20 = 0; d21 = 0;
    for (int k = 0; k < 3; k++) begin
      e0[k] = coord_at(it.vert1, k) - coord_at(it.vert0, k);
      e1[k] = coord_at(it.vert2, k) - coord_at(it.vert0, k);
      p[k]  = coord_at(it.sample_point, k) - coord_at(it.vert0, k);
      d00 += e0[k] * e0[k];
      d01 += e0[k] * e1[k];
      d11 += e1[k] * e1[k];
      d20 += p[k] * e0[k];
      d21 += p[k] * e1[k];
    end
    denom = d00 * d11 - d01 * d01;
    r = '0;
    if (denom <= 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    nv  = d11 * d20 - d01 * d21;
    nw  = d00 * d21 - d01 * d20;
    wv  = (nv <<< bary_pkg::WFB) / denom;
    ww  = (nw <<< bary_pkg::WFB) / denom;
    one = 1;
    wu  = (one <<< bary_pkg::WFB) - wv - ww;
    su  = tex_at(it.tex0, 0) * wu + tex_at(it.tex1, 0) * wv + tex_at(it.tex2, 0) * ww;
    sv  = tex_at(it.tex0, 1) * wu + tex_at(it.tex1, 1) * wv + tex_at(it.tex2, 1) * ww;
    r.tex_u = clamp_q412(su);
    r.tex_v = clamp_q412(sv);
    return r;
  endfunction

  function automatic logic [47:0] vtx(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    return {z, y, x};
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [31:0] rand_tex();
    logic [31:0] t;
    t = $urandom;
    if ($urandom_range(0, 2) == 0) begin
      t = {16'($signed(12'($urandom))), 16'($signed(12'($urandom)))};
    end
    return t;
  endfunction

  function automatic bary_pkg::in_item_t rand_item();
    bary_pkg::in_item_t it;
    logic [15:0] b[3], d[3];
    int mode;
    mode = $urandom_range(0, 9);
    it.tex0 = rand_tex();
    it.tex1 = rand_tex();
    it.tex2 = rand_tex();
    it.vert0 = rand48();
    it.vert1 = rand48();
    it.vert2 = rand48();
    it.sample_point = rand48();
    for (int k = 0; k < 3; k++) begin
      b[k] = 16'($urandom_range(0, 16'h8000));
      d[k] = 16'($urandom_range(0, 16'h0fff));
    end
    case (mode)
      0, 1, 2: ;
      3, 4: begin
        // small triangle with nearby point
        it.vert0 = vtx(b[0], b[1], b[2]);
        it.vert1 = vtx(16'(b[0] + $urandom_range(0, 255)), 16'(b[1] + $urandom_range(0, 255)),
                       16'(b[2] + $urandom_range(0, 255)));
        it.vert2 = vtx(16'(b[0] + $urandom_range(0, 255)), 16'(b[1] + $urandom_range(0, 255)),
                       16'(b[2] + $urandom_range(0, 255)));
        it.sample_point = vtx(16'(b[0] + $urandom_range(0, 300)),
                              16'(b[1] + $urandom_range(0, 300)),
                              16'(b[2] + $urandom_range(0, 300)));
      end
      5, 6, 7: begin
        // point at the centroid
        for (int k = 0; k < 3; k++) begin
          it.sample_point[16*k +: 16] = 16'((32'(it.vert0[16*k +: 16]) +
            32'(it.vert1[16*k +: 16]) + 32'(it.vert2[16*k +: 16])) / 3);
        end
      end
      default: begin
        // collinear or coincident vertices
        it.vert0 = vtx(b[0], b[1], b[2]);
        it.vert1 = vtx(b[0] + d[0], b[1] + d[1], b[2] + d[2]);
        it.vert2 = (mode == 8) ? vtx(16'(b[0] + 2*d[0]), 16'(b[1] + 2*d[1]),
                                     16'(b[2] + 2*d[2]))
                               : it.vert0;
      end
    endcase
    return it;
  endfunction

  // stimulus side
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_uv = {expected_uv, interp_uv(pending_items.pop_front())};
        accepted_count++;
        no_idle_burst = ((accepted_count / 150) % 3) == 2;
        send_gap = no_idle_burst ? 0 : $urandom_range(0, 3);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= pending_items[0];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    bary_pkg::out_item_t exp_r;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (out_ch.valid && out_ch.ready) begin
      if (expected_uv.size() == 0) begin
        $error("unexpected result item: tex_u=%0d tex_v=%0d degenerate=%0b",
               out_ch.data.tex_u, out_ch.data.tex_v, out_ch.data.degenerate);
        fail_count++;
      end else begin
        exp_r = expected_uv.pop_front();
        if (out_ch.data.tex_u !== exp_r.tex_u) begin
          $error("tex_u: expected %0d, got %0d", exp_r.tex_u, out_ch.data.tex_u);
          fail_count++;
        end
        if (out_ch.data.tex_v !== exp_r.tex_v) begin
          $error("tex_v: expected %0d, got %0d", exp_r.tex_v, out_ch.data.tex_v);
          fail_count++;
        end
        if (out_ch.data.degenerate !== exp_r.degenerate) begin
          $error("degenerate: expected %0b, got %0b", exp_r.degenerate,
                 out_ch.data.degenerate);
          fail_count++;
        end
      end
      take_stall = no_idle_burst ? 0 : $urandom_range(0, 3);
      out_ch.ready <= (take_stall == 0);
    end else if (!out_ch.ready) begin
      if (take_stall > 0) take_stall--;
      out_ch.ready <= (take_stall == 0);
    end
  end

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    bary_pkg::in_item_t it;
    logic [15:0] xs[4];
    rst = 1'b1;
    xs = '{16'h0000, 16'h0010, 16'h0800, 16'hffff};
    // coincident vertices, all zeros and all ones
    queue_item('0);
    queue_item('1);
    // right triangle in the xy plane; point at each vertex, centroid, far off
    it.vert0 = vtx(16'h0000, 16'h0000, 16'h0000);
    it.vert1 = vtx(16'h0010, 16'h0000, 16'h0000);
    it.vert2 = vtx(16'h0000, 16'h0010, 16'h0000);
    it.tex0 = {16'h7fff, 16'h8000};
    it.tex1 = {16'h8000, 16'h7fff};
    it.tex2 = {16'h1000, 16'hf000};
    it.sample_point = it.vert0; queue_item(it);
    it.sample_point = it.vert1; queue_item(it);
    it.sample_point = it.vert2; queue_item(it);
    it.sample_point = vtx(16'h0005, 16'h0005, 16'h0000); queue_item(it);
    it.sample_point = vtx(16'h0008, 16'h0008, 16'hffff); queue_item(it);
    for (int i = 0; i < 4; i++) begin
      // far points push the sums into saturation both ways
      it.sample_point = vtx(xs[i], xs[3 - i], xs[i]);
      queue_item(it);
    end
    it.tex0 = 32'hffff_ffff; it.tex1 = '0; it.tex2 = 32'h7fff_7fff;
    it.sample_point = 48'hffff_ffff_ffff; queue_item(it);
    // largest triangle
    it.vert0 = vtx(16'h0000, 16'h0000, 16'hffff);
    it.vert1 = vtx(16'hffff, 16'h0000, 16'h0000);
    it.vert2 = vtx(16'h0000, 16'hffff, 16'h0000);
    it.sample_point = vtx(16'h5555, 16'h5555, 16'h5555); queue_item(it);
    it.sample_point = '0; queue_item(it);
    // collinear vertices
    it.vert0 = vtx(16'h0001, 16'h0002, 16'h0003);
    it.vert1 = vtx(16'h0003, 16'h0006, 16'h0009);
    it.vert2 = vtx(16'h0100, 16'h0200, 16'h0300);
    queue_item(it);
    for (int i = 0; i < 1335; i++) queue_item(rand_item());

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait (pending_items.size() == 0 && expected_uv.size() == 0);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && expected_uv.size() == 0) begin
      $display("tb_barycentric_uv_interpolate OK");
    end else begin
      $display("tb_barycentric_uv_interpolate NOT OK");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tb_barycentric_uv_interpolate NOT OK");
    $finish;
  end

endmodule

### barycentric_uv_interpolate.f
src/bary_pkg.sv
src/bary_if.sv
src/bary_front.sv
src/bary_queue.sv
src/bary_div.sv
src/bary_back.sv
src/barycentric_uv_interpolate.sv
tb/tb_barycentric_uv_interpolate.sv
